FILE: hdl/rtc_pkg.sv
// Shared types, constants and calendar helper functions for the RTC calendar counter.
// Used by every module under hdl; depends on nothing else.

package rtc_pkg;

	localparam int YEAR_BITS = 16;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	localparam logic [5:0] SEC_MAX   = 6'd59;
	localparam logic [5:0] MIN_MAX   = 6'd59;
	localparam logic [4:0] HOUR_MAX  = 5'd23;
	localparam logic [4:0] DAY_FIRST = 5'd1;
	localparam logic [4:0] DAY_MAX   = 5'd31;
	localparam logic [4:0] FEB_LEAP  = 5'd29;
	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_MAX = 4'd12;
	localparam logic [3:0] WEEK_DAYS = 4'd7;

	localparam logic [YEAR_BITS-1:0] YEAR_ONE = YEAR_BITS'(1);

	// divisibility by 25 on a 16-bit year: y*inv(25) mod 2^16 <= floor((2^16-1)/25)
	localparam logic [15:0] INV25     = 16'd23593;
	localparam logic [15:0] DIV25_LIM = 16'd2621;

	// weekday: p = year + 399, floor(p/100) = (p * 83887) >> 23, exact for p < 91180
	localparam logic [16:0] YEAR_BIAS   = 17'd399;
	localparam logic [16:0] RECIP100    = 17'd83887;
	localparam int          RECIP_SHIFT = 23;
	localparam int          CENT_W      = 10;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	localparam logic [8:0] CUM_DAYS [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic       cmd;
		logic [5:0] set_seconds;
		logic [5:0] set_minutes;
		logic [4:0] set_hours;
		logic [4:0] set_day;
		logic [3:0] set_month;
		logic [15:0] set_year;
	} req_t;

	typedef struct packed {
		logic [5:0]  seconds_now;
		logic [5:0]  minutes_now;
		logic [4:0]  hours_now;
		logic [4:0]  day_now;
		logic [3:0]  month_now;
		logic [15:0] year_now;
		logic [2:0]  weekday_now;
		logic        minute_rolled;
	} rsp_t;

	typedef struct packed {
		logic [5:0]           sec;
		logic [5:0]           min;
		logic [4:0]           hour;
		logic [4:0]           day;
		logic [3:0]           month;
		logic [YEAR_BITS-1:0] year;
	} date_t;

	typedef struct packed {
		req_t req;
		logic clear;
		logic leap;
	} prep_t;

	typedef struct packed {
		date_t date;
		logic  leap;
		logic  wd_calc;
		logic  rolled;
	} date_word_t;

	typedef struct packed {
		logic ld_s0;
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} pipe_ctl_t;

	function automatic logic is_leap(input logic [15:0] year);
		logic [15:0] prod;
		logic        div25;
		prod  = year * INV25;
		div25 = prod <= DIV25_LIM;
		return (div25 && year[3:0] == 4'd0) || (!div25 && year[1:0] == 2'd0);
	endfunction

	function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		if (month == 4'd0 || month > MONTH_MAX) begin
			len = DAY_MAX;
		end else if (month == MONTH_FEB && leap) begin
			len = FEB_LEAP;
		end else begin
			len = MONTH_LEN[month - 4'd1];
		end
		return len;
	endfunction

	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] cum;
		if (month == 4'd0 || month > MONTH_MAX) begin
			cum = 9'd0;
		end else begin
			cum = CUM_DAYS[month - 4'd1];
		end
		return cum;
	endfunction

endpackage

FILE: hdl/rtc_load_prep.sv
// Input register stage: captures the request word and pre-decodes load checks.
// Depends on rtc_pkg (req_t, prep_t, is_leap).

module rtc_load_prep (
	input  logic              clk,
	input  rtc_pkg::pipe_ctl_t ctl,
	input  rtc_pkg::req_t      req,
	output rtc_pkg::prep_t     prep
);

	rtc_pkg::prep_t prep_nxt;
	rtc_pkg::prep_t prep_s0;

	always_comb begin
		prep_nxt.req   = req;
		prep_nxt.clear = req.set_seconds > rtc_pkg::SEC_MAX ||
		                 req.set_minutes > rtc_pkg::MIN_MAX ||
		                 req.set_hours > rtc_pkg::HOUR_MAX;
		// cleared clock lands in year 0, which is leap
		prep_nxt.leap  = prep_nxt.clear ? 1'b1 :
		                 rtc_pkg::is_leap(16'(req.set_year[rtc_pkg::YEAR_BITS-1:0]));
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s0) begin
			prep_s0 <= prep_nxt;
		end
	end

	assign prep = prep_s0;

endmodule

FILE: hdl/rtc_date_unit.sv
// Clock state: seconds through year, advanced by a tick or replaced by a load.
// Depends on rtc_pkg (date_t, prep_t, date_word_t, days_in_month, is_leap).

module rtc_date_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rtc_pkg::pipe_ctl_t    ctl,
	input  rtc_pkg::prep_t        prep,
	output rtc_pkg::date_word_t   word
);

	rtc_pkg::date_t clock_q;
	logic           leap_q;
	logic           wd_calc_s1;
	logic           rolled_s1;

	rtc_pkg::date_t tick_date;
	rtc_pkg::date_t load_date;
	logic           is_load;
	logic [4:0]     dim_cur;
	logic [4:0]     dim_ld;
	logic [3:0]     ld_month;
	logic           sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
	logic           day_chg;

	always_comb begin
		is_load    = prep.req.cmd == rtc_pkg::CMD_LOAD;
		dim_cur    = rtc_pkg::days_in_month(clock_q.month, leap_q);
		sec_wrap   = clock_q.sec >= rtc_pkg::SEC_MAX;
		min_wrap   = clock_q.min >= rtc_pkg::MIN_MAX;
		hour_wrap  = clock_q.hour >= rtc_pkg::HOUR_MAX;
		day_wrap   = clock_q.day >= dim_cur;
		month_wrap = clock_q.month >= rtc_pkg::MONTH_MAX;
		day_chg    = sec_wrap && min_wrap && hour_wrap;

		tick_date     = clock_q;
		tick_date.sec = sec_wrap ? 6'd0 : clock_q.sec + 6'd1;
		if (sec_wrap) begin
			tick_date.min = min_wrap ? 6'd0 : clock_q.min + 6'd1;
		end
		if (sec_wrap && min_wrap) begin
			tick_date.hour = hour_wrap ? 5'd0 : clock_q.hour + 5'd1;
		end
		if (day_chg) begin
			tick_date.day = day_wrap ? rtc_pkg::DAY_FIRST : clock_q.day + 5'd1;
		end
		if (day_chg && day_wrap) begin
			tick_date.month = month_wrap ? rtc_pkg::MONTH_JAN : clock_q.month + 4'd1;
		end
		if (day_chg && day_wrap && month_wrap) begin
			tick_date.year = clock_q.year + rtc_pkg::YEAR_ONE;
		end

		// load: clear on bad time, clamp month, saturate day
		if (prep.clear || prep.req.set_month == 4'd0) begin
			ld_month = rtc_pkg::MONTH_JAN;
		end else if (prep.req.set_month > rtc_pkg::MONTH_MAX) begin
			ld_month = rtc_pkg::MONTH_MAX;
		end else begin
			ld_month = prep.req.set_month;
		end
		dim_ld = rtc_pkg::days_in_month(ld_month, prep.leap);

		load_date.sec   = prep.clear ? 6'd0 : prep.req.set_seconds;
		load_date.min   = prep.clear ? 6'd0 : prep.req.set_minutes;
		load_date.hour  = prep.clear ? 5'd0 : prep.req.set_hours;
		load_date.month = ld_month;
		load_date.year  = prep.clear ? '0 : prep.req.set_year[rtc_pkg::YEAR_BITS-1:0];
		if (prep.clear || prep.req.set_day == 5'd0) begin
			load_date.day = rtc_pkg::DAY_FIRST;
		end else if (prep.req.set_day > dim_ld) begin
			load_date.day = dim_ld;
		end else begin
			load_date.day = prep.req.set_day;
		end
	end

	// leap flag follows a year rollover in the next cycle; the date is then in January
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q.sec   <= 6'd0;
			clock_q.min   <= 6'd0;
			clock_q.hour  <= 5'd0;
			clock_q.day   <= rtc_pkg::DAY_FIRST;
			clock_q.month <= rtc_pkg::MONTH_JAN;
			clock_q.year  <= '0;
			leap_q        <= 1'b1;
			wd_calc_s1    <= 1'b0;
			rolled_s1     <= 1'b0;
		end else begin
			if (ctl.ld_s1) begin
				clock_q    <= is_load ? load_date : tick_date;
				wd_calc_s1 <= is_load || day_chg;
				rolled_s1  <= !is_load && sec_wrap;
			end
			if (ctl.ld_s1 && is_load) begin
				leap_q <= prep.leap;
			end else begin
				leap_q <= rtc_pkg::is_leap(16'(clock_q.year));
			end
		end
	end

	always_comb begin
		word.date    = clock_q;
		word.leap    = leap_q;
		word.wd_calc = wd_calc_s1;
		word.rolled  = rolled_s1;
	end

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		clock_q.sec <= rtc_pkg::SEC_MAX && clock_q.min <= rtc_pkg::MIN_MAX &&
		clock_q.hour <= rtc_pkg::HOUR_MAX)
		else $error("time of day out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		clock_q.month >= rtc_pkg::MONTH_JAN && clock_q.month <= rtc_pkg::MONTH_MAX &&
		clock_q.day >= rtc_pkg::DAY_FIRST &&
		clock_q.day <= rtc_pkg::days_in_month(clock_q.month, leap_q))
		else $error("date out of range");

	a_leap_track: assert property (@(posedge clk) disable iff (!arst_n)
		leap_q == rtc_pkg::is_leap(16'(clock_q.year)) || clock_q.month == rtc_pkg::MONTH_JAN)
		else $error("leap flag out of step with year");

endmodule

FILE: hdl/rtc_weekday_unit.sv
// Weekday pipeline and result register: day-of-year, century count, mod-7 reduction.
// Depends on rtc_pkg (date_word_t, rsp_t, days_before, weekday constants).

module rtc_weekday_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rtc_pkg::pipe_ctl_t   ctl,
	input  rtc_pkg::date_word_t  word,
	output rtc_pkg::rsp_t        rsp
);

	logic [16:0] p;
	logic [33:0] prod;
	logic [8:0]  doy;
	logic [16:0] acc;

	rtc_pkg::date_t            date_s2;
	logic [rtc_pkg::CENT_W-1:0] cent_s2;
	logic [16:0]               acc_s2;
	logic                      wd_calc_s2;
	logic                      rolled_s2;

	logic [16:0] wsum;
	logic [5:0]  fold1;
	logic [3:0]  fold2;
	logic [3:0]  rem7;
	logic [2:0]  wd_new;

	rtc_pkg::date_t date_s3;
	logic           rolled_s3;
	logic [2:0]     wd_q;

	// stage 2: p = year + 399, p/100 by reciprocal, day of year
	always_comb begin
		p    = 17'(word.date.year) + rtc_pkg::YEAR_BIAS;
		prod = {17'd0, p} * {17'd0, rtc_pkg::RECIP100};
		doy  = rtc_pkg::days_before(word.date.month) + 9'(word.date.day) +
		       9'(word.leap && word.date.month > rtc_pkg::MONTH_FEB);
		acc  = p + {2'd0, p[16:2]} + 17'(doy);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			date_s2    <= word.date;
			cent_s2    <= prod[rtc_pkg::RECIP_SHIFT +: rtc_pkg::CENT_W];
			acc_s2     <= acc;
			wd_calc_s2 <= word.wd_calc;
			rolled_s2  <= word.rolled;
		end
	end

	// stage 3: subtract p/100, add p/400, reduce mod 7 (8 == 1 mod 7)
	always_comb begin
		wsum   = acc_s2 - 17'(cent_s2) + 17'(cent_s2[rtc_pkg::CENT_W-1:2]);
		fold1  = 6'(wsum[2:0]) + 6'(wsum[5:3]) + 6'(wsum[8:6]) +
		         6'(wsum[11:9]) + 6'(wsum[14:12]) + 6'(wsum[16:15]);
		fold2  = 4'(fold1[5:3]) + 4'(fold1[2:0]);
		rem7   = (fold2 >= rtc_pkg::WEEK_DAYS) ? fold2 - rtc_pkg::WEEK_DAYS : fold2;
		wd_new = rem7[2:0] + 3'd1;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			date_s3   <= date_s2;
			rolled_s3 <= rolled_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_q <= 3'd1;
		end else if (ctl.ld_s3 && wd_calc_s2) begin
			wd_q <= wd_new;
		end
	end

	always_comb begin
		rsp.seconds_now   = date_s3.sec;
		rsp.minutes_now   = date_s3.min;
		rsp.hours_now     = date_s3.hour;
		rsp.day_now       = date_s3.day;
		rsp.month_now     = date_s3.month;
		rsp.year_now      = 16'(date_s3.year);
		rsp.weekday_now   = wd_q;
		rsp.minute_rolled = rolled_s3;
	end

	a_wd_range: assert property (@(posedge clk) disable iff (!arst_n)
		wd_q != 3'd0)
		else $error("weekday zero");

	a_wd_update: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ld_s3 && wd_calc_s2 |=> wd_q == $past(wd_new))
		else $error("weekday not taken on day change");

endmodule

FILE: hdl/rtc_calendar_counter.sv
// Top level of the RTC calendar counter: stage handshake and unit wiring.
// Depends on rtc_pkg, rtc_load_prep, rtc_date_unit, rtc_weekday_unit.

// Each request word is a one-second tick or a load of time and date; every accepted word
// gives exactly one response word with the clock after the update. The block takes one word
// per cycle while req_stall is low; each word passes the input register, date update,
// reciprocal multiply for the century count, and mod-7 weekday reduction that feeds the
// response register. Each stage moves on when its successor has room, so a stalled response
// leaves up to three more words accepted behind it before req_stall rises. The weekday is
// recomputed on every load and on every day change, and is 7 (Saturday) after a load that
// clears the clock; after reset it reads 1 until first recomputed.

module rtc_calendar_counter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rtc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rtc_pkg::rsp_t rsp
);

	logic vld_s0, vld_s1, vld_s2, vld_s3;
	logic en_s0, en_s1, en_s2, en_s3;

	rtc_pkg::pipe_ctl_t  ctl;
	rtc_pkg::prep_t      prep;
	rtc_pkg::date_word_t word;

	always_comb begin
		en_s3 = !vld_s3 || !rsp_stall;
		en_s2 = !vld_s2 || en_s3;
		en_s1 = !vld_s1 || en_s2;
		en_s0 = !vld_s0 || en_s1;

		ctl.ld_s0 = req_valid && en_s0;
		ctl.ld_s1 = vld_s0 && en_s1;
		ctl.ld_s2 = vld_s1 && en_s2;
		ctl.ld_s3 = vld_s2 && en_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en_s0) begin
				vld_s0 <= req_valid;
			end
			if (en_s1) begin
				vld_s1 <= vld_s0;
			end
			if (en_s2) begin
				vld_s2 <= vld_s1;
			end
			if (en_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	assign req_stall = !en_s0;
	assign rsp_valid = vld_s3;

	rtc_load_prep u_prep (
		.clk  (clk),
		.ctl  (ctl),
		.req  (req),
		.prep (prep)
	);

	rtc_date_unit u_date (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.prep   (prep),
		.word   (word)
	);

	rtc_weekday_unit u_wday (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.word   (word),
		.rsp    (rsp)
	);

	a_rolled_sec: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.minute_rolled |-> rsp.seconds_now == 6'd0)
		else $error("minute rollover without seconds at zero");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for rtc_calendar_counter: directed loads and rollovers, then random
// load-and-tick runs, checked word by word against a calendar predictor kept in the bench.
// Depends on rtc_pkg and rtc_calendar_counter.
`timescale 1ns / 100ps

module testbench;

	localparam int ITEM_TARGET  = 1300;
	localparam int QUIET_TAIL   = 150;
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 80;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_REPORTS  = 10;

	localparam int unsigned NORMAL_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	rtc_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rtc_pkg::rsp_t rsp;

	rtc_pkg::req_t pending_words [$];
	rtc_pkg::rsp_t expected_clock [$];

	// predicted calendar state
	logic [5:0]                    cal_sec;
	logic [5:0]                    cal_min;
	logic [4:0]                    cal_hour;
	logic [4:0]                    cal_day;
	logic [3:0]                    cal_month;
	logic [rtc_pkg::YEAR_BITS-1:0] cal_year;
	logic [2:0]                    cal_wday;

	int  total_words = 0;
	int  words_in = 0;
	int  words_out = 0;
	int  error_count = 0;
	int  report_count = 0;
	int  cycle_count = 0;
	int  loads_seen = 0;
	int  clears_seen = 0;
	int  rolls_seen = 0;
	int  days_seen = 0;
	int  send_gap = 0;
	int  rsp_gap = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  req_sent = 1'b0;

	wire idling_on = (words_in < total_words - QUIET_TAIL) && ((words_in / 128) % 4 != 3);
	wire send_idle_on = idling_on && !(words_in >= HOLD_AT - 10 && words_in <= HOLD_AT + 30);

	rtc_calendar_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		int unsigned len;
		if (m < 1 || m > 12) begin
			len = 31;
		end else if (m == 2 && leap_year(y)) begin
			len = 29;
		end else begin
			len = NORMAL_DAYS[m - 1];
		end
		return len;
	endfunction

	function automatic logic [2:0] day_of_week(input int unsigned d, input int unsigned m,
			input int unsigned y);
		int unsigned doy;
		int unsigned i;
		int unsigned p;
		doy = d;
		for (i = 1; i < m && i <= 12; i++) begin
			doy += NORMAL_DAYS[i - 1];
		end
		if (m > 2 && leap_year(y)) begin
			doy += 1;
		end
		p = y + 399;
		return 3'((p + p / 4 - p / 100 + p / 400 + doy) % 7 + 1);
	endfunction

	function automatic rtc_pkg::rsp_t predict_clock(input rtc_pkg::req_t w);
		int unsigned s, mi, h, d, m, y, len;
		logic rolled;
		rtc_pkg::rsp_t r;
		rolled = 1'b0;
		if (w.cmd == rtc_pkg::CMD_LOAD) begin
			s = 32'(w.set_seconds);
			mi = 32'(w.set_minutes);
			h = 32'(w.set_hours);
			d = 32'(w.set_day);
			m = 32'(w.set_month);
			y = 32'(w.set_year);
			if (s > 59 || mi > 59 || h > 23) begin
				s = 0;
				mi = 0;
				h = 0;
				d = 1;
				m = 1;
				y = 0;
				clears_seen++;
			end
			y = y % (1 << rtc_pkg::YEAR_BITS);
			if (m < 1) m = 1;
			if (m > 12) m = 12;
			len = month_days(m, y);
			if (d < 1) d = 1;
			if (d > len) d = len;
			cal_sec = 6'(s);
			cal_min = 6'(mi);
			cal_hour = 5'(h);
			cal_day = 5'(d);
			cal_month = 4'(m);
			cal_year = y[rtc_pkg::YEAR_BITS-1:0];
			cal_wday = day_of_week(d, m, y);
			loads_seen++;
		end else if (cal_sec >= 59) begin
			cal_sec = 0;
			rolled = 1'b1;
			rolls_seen++;
			if (cal_min >= 59) begin
				cal_min = 0;
				if (cal_hour >= 23) begin
					cal_hour = 0;
					days_seen++;
					if (32'(cal_day) + 1 > month_days(32'(cal_month), 32'(cal_year))) begin
						cal_day = 1;
						if (cal_month >= 12) begin
							cal_month = 1;
							cal_year = cal_year + 1'b1;
						end else begin
							cal_month = cal_month + 1'b1;
						end
					end else begin
						cal_day = cal_day + 1'b1;
					end
					cal_wday = day_of_week(32'(cal_day), 32'(cal_month), 32'(cal_year));
				end else begin
					cal_hour = cal_hour + 1'b1;
				end
			end else begin
				cal_min = cal_min + 1'b1;
			end
		end else begin
			cal_sec = cal_sec + 1'b1;
		end
		r.seconds_now = cal_sec;
		r.minutes_now = cal_min;
		r.hours_now = cal_hour;
		r.day_now = cal_day;
		r.month_now = cal_month;
		r.year_now = 16'(cal_year);
		r.weekday_now = cal_wday;
		r.minute_rolled = rolled;
		return r;
	endfunction

	task automatic push_load(input int unsigned s, input int unsigned mi, input int unsigned h,
			input int unsigned d, input int unsigned m, input int unsigned y);
		rtc_pkg::req_t w;
		w.cmd = rtc_pkg::CMD_LOAD;
		w.set_seconds = 6'(s);
		w.set_minutes = 6'(mi);
		w.set_hours = 5'(h);
		w.set_day = 5'(d);
		w.set_month = 4'(m);
		w.set_year = 16'(y);
		pending_words.push_back(w);
	endtask

	// tick words carry random junk in the load fields
	task automatic push_ticks(input int n);
		rtc_pkg::req_t w;
		logic [63:0]   junk;
		repeat (n) begin
			junk = {$urandom, $urandom};
			w = junk[$bits(rtc_pkg::req_t)-1:0];
			w.cmd = rtc_pkg::CMD_TICK;
			pending_words.push_back(w);
		end
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_sent)) begin
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (pending_words.size() == 0) begin
				req_valid <= 1'b0;
			end else if (send_idle_on && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(1, 11) - 1;
				req_valid <= 1'b0;
			end else begin
				req <= pending_words.pop_front();
				req_valid <= 1'b1;
			end
		end
	end

	// receiver backpressure, with one long hold-off to fill the pipeline
	always @(negedge clk) begin
		if (!hold_done && words_in >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			rsp_stall <= 1'b1;
		end else if (idling_on && $urandom_range(0, 7) == 0) begin
			rsp_gap = $urandom_range(1, 11) - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// accept, predict and check
	always @(posedge clk) begin
		rtc_pkg::rsp_t want;
		req_sent <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			expected_clock.push_back(predict_clock(req));
			words_in <= words_in + 1;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			words_out <= words_out + 1;
			if (expected_clock.size() == 0) begin
				error_count++;
				report_count++;
				if (report_count <= MAX_REPORTS)
					$display("%0t: unexpected word %p", $realtime, rsp);
			end else begin
				want = expected_clock.pop_front();
				if (rsp !== want) begin
					error_count++;
					report_count++;
					if (report_count <= MAX_REPORTS)
						$display({"%0t: mismatch got %0d:%0d:%0d %0d/%0d/%0d wd %0d roll %0d,",
							" want %0d:%0d:%0d %0d/%0d/%0d wd %0d roll %0d"}, $realtime,
							rsp.hours_now, rsp.minutes_now, rsp.seconds_now, rsp.day_now,
							rsp.month_now, rsp.year_now, rsp.weekday_now, rsp.minute_rolled,
							want.hours_now, want.minutes_now, want.seconds_now, want.day_now,
							want.month_now, want.year_now, want.weekday_now,
							want.minute_rolled);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d words in", cycle_count, words_in,
				total_words);
			$display("testbench: errors");
			$finish;
		end
	end

	initial begin
		int unsigned m, y, d, pick;
		cal_sec = 0;
		cal_min = 0;
		cal_hour = 0;
		cal_day = 1;
		cal_month = 1;
		cal_year = 0;
		cal_wday = 1;

		// directed
		push_ticks(2);
		push_load(59, 59, 23, 31, 12, 65535);
		push_ticks(2);
		push_load(59, 59, 23, 28, 2, 2000);
		push_ticks(1);
		push_load(59, 59, 23, 28, 2, 1900);
		push_ticks(1);
		push_load(59, 59, 23, 29, 2, 2024);
		push_ticks(1);
		push_load(0, 0, 0, 15, 3, 2024);
		push_load(63, 0, 0, 10, 5, 2020);
		push_load(0, 60, 0, 10, 5, 2020);
		push_load(0, 0, 24, 10, 5, 2020);
		push_load(0, 63, 31, 31, 15, 65535);
		push_load(0, 0, 0, 0, 0, 2023);
		push_load(0, 0, 0, 31, 15, 2023);
		push_load(0, 0, 0, 31, 2, 2023);
		push_load(0, 0, 0, 31, 2, 2024);
		push_load(59, 59, 23, 31, 4, 2021);
		push_ticks(1);
		push_load(58, 59, 12, 1, 1, 0);
		push_ticks(2);

		// random: mostly loads just short of a rollover followed by ticks
		while (pending_words.size() < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick <= 5) begin
				m = $urandom_range(1, 12);
				case ($urandom_range(0, 5))
					0: y = $urandom_range(0, 65535);
					1: y = $urandom_range(0, 655) * 100;
					2: y = $urandom_range(0, 163) * 400;
					3: y = 65535 - $urandom_range(0, 1);
					4: y = $urandom_range(0, 16383) * 4;
					default: y = $urandom_range(1900, 2100);
				endcase
				if ($urandom_range(0, 3) == 0) begin
					d = $urandom_range(1, 31);
				end else begin
					d = month_days(m, y) - $urandom_range(0, 1);
				end
				if ($urandom_range(0, 4) == 0) m = 12;
				push_load($urandom_range(50, 59),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59,
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23,
					d, m, y);
				push_ticks($urandom_range(1, 12));
			end else if (pick <= 7) begin
				push_load($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 65535));
				push_ticks($urandom_range(1, 3));
			end else begin
				push_ticks($urandom_range(1, 20));
			end
		end
		total_words = pending_words.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_in < total_words) @(posedge clk);
		while (expected_clock.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (expected_clock.size() != 0) begin
			error_count += expected_clock.size();
			$display("%0d expected words never arrived", expected_clock.size());
		end
		$display("covered %0d words: %0d loads (%0d out-of-range clears), %0d ticks,",
			total_words, loads_seen, clears_seen, total_words - loads_seen);
		$display("  %0d minute rollovers, %0d day changes, %0d mismatches", rolls_seen,
			days_seen, error_count);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
